>>> hw/rtl/iad_pkg.sv
// Shared constants and the digit-to-ASCII function of the integer to ASCII digit converter.
// Has no dependencies.
package iad_pkg;

  localparam int IN_W        = 64;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int VALUE_WIDTH = 64;

  localparam int STEP        = 8;
  localparam int NCHUNK      = (VALUE_WIDTH + STEP - 1) / STEP;
  localparam int QW          = NCHUNK * STEP;
  localparam int CNT_W       = $clog2(NCHUNK + 1);
  localparam int ND_W        = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W       = $clog2(VALUE_WIDTH);

  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LETTER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [BASE_W-1:0] DECIMAL     = 6'd10;
  localparam logic [BASE_W-1:0] MAX_RADIX   = 6'd36;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DECIMAL) begin
      ch = CH_ZERO + CHAR_W'(d);
    end else begin
      ch = CH_LETTER_A + CHAR_W'(d - DECIMAL);
    end
    return ch;
  endfunction

endpackage

>>> hw/rtl/integer_to_ascii_digits.sv
// Integer to ASCII digit converter: one number in, its digits out, most significant first.
// Steps: value zero or radix below two loads the single '0' directly. Otherwise each digit takes a
// setup step plus one divider pass per byte up to the highest nonzero byte of the remaining quotient in the shared
// 8-bit-per-cycle restoring divider; a sign check follows the last digit and emits a '-' when negative,
// then each digit character goes through digit RAM read, output load and handshake.
// Throughput: one number at a time; in_stall is high until the last character is taken.
// Reset: synchronous, active low; clears the sequencer and output valid, not the digit RAM.
module integer_to_ascii_digits (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [iad_pkg::IN_W-1:0]  in_value,
  input  logic [iad_pkg::BASE_W-1:0]       in_base,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [iad_pkg::CHAR_W-1:0]       out_character,
  output logic                             out_last
);
  import iad_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_FILL = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] v_r, v_nxt;
  logic [BASE_W-1:0]      radix_r, radix_nxt;
  logic                   neg_r, neg_nxt;
  logic [QW-1:0]          q_r, q_nxt;
  logic [BASE_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ND_W-1:0]        nd_r, nd_nxt;
  logic [CHAR_W-1:0]      char_r, char_nxt;
  logic                   last_r, last_nxt;
  logic                   valid_r, valid_nxt;

  logic [CHAR_W-1:0]      mem [VALUE_WIDTH];
  logic [CHAR_W-1:0]      rd_r;
  logic [IDX_W-1:0]       rd_idx;
  logic                   wr_en;
  logic [CHAR_W-1:0]      wr_data;

  logic [VALUE_WIDTH-1:0] vin;
  logic [BASE_W-1:0]      base_sat;
  logic                   in_neg;
  logic [QW-1:0]          vpad;
  logic [CNT_W-1:0]       nch;
  logic [QW-1:0]          q_load;
  logic [QW-1:0]          qx;
  logic [BASE_W-1:0]      rx;

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

  assign vin      = in_value[VALUE_WIDTH-1:0];
  assign base_sat = (in_base > MAX_RADIX) ? MAX_RADIX : in_base;
  assign in_neg   = (base_sat == DECIMAL) && vin[VALUE_WIDTH-1];
  assign vpad     = QW'(v_r);
  assign rd_idx   = IDX_W'(nd_r - 1'b1);

  always_comb begin
    nch = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      if (vpad[i*STEP +: STEP] != '0) begin
        nch = CNT_W'(i + 1);
      end
    end
  end

  assign q_load = vpad << (STEP * (NCHUNK - int'(nch)));

  always_comb begin
    logic [BASE_W:0] t;
    qx = q_r;
    rx = rem_r;
    for (int k = 0; k < STEP; k++) begin
      t  = {rx, qx[QW-1]};
      qx = {qx[QW-2:0], 1'b0};
      if (t >= {1'b0, radix_r}) begin
        rx    = BASE_W'(t - {1'b0, radix_r});
        qx[0] = 1'b1;
      end else begin
        rx = t[BASE_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    nd_nxt    = nd_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    valid_nxt = valid_r;
    wr_en     = 1'b0;
    wr_data   = digit_char(rx);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          nd_nxt    = '0;
          radix_nxt = base_sat;
          neg_nxt   = in_neg;
          v_nxt     = in_neg ? (~vin + 1'b1) : vin;
          if ((vin == '0) || (in_base < 6'd2)) begin
            char_nxt  = CH_ZERO;
            last_nxt  = 1'b1;
            valid_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        if (v_r == '0) begin
          state_nxt = ST_SIGN;
        end else begin
          q_nxt     = q_load;
          rem_nxt   = '0;
          cnt_nxt   = nch;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        q_nxt   = qx;
        rem_nxt = rx;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          wr_en     = 1'b1;
          nd_nxt    = nd_r + 1'b1;
          v_nxt     = qx[VALUE_WIDTH-1:0];
          state_nxt = ST_PREP;
        end
      end
      ST_SIGN: begin
        if (neg_r) begin
          char_nxt  = CH_MINUS;
          last_nxt  = 1'b0;
          valid_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        char_nxt  = rd_r;
        last_nxt  = (nd_r == ND_W'(1));
        valid_nxt = 1'b1;
        nd_nxt    = nd_r - 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          valid_nxt = 1'b0;
          state_nxt = last_r ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      nd_r    <= '0;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      nd_r    <= nd_nxt;
      cnt_r   <= cnt_nxt;
      neg_r   <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    radix_r <= radix_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[nd_r[IDX_W-1:0]] <= wr_data;
    end
    rd_r <= mem[rd_idx];
  end

`ifndef SYNTHESIS
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> in_stall)
    else $error("Output word pending while input is open.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (char_r == CH_MINUS)) |-> (!last_r && neg_r))
    else $error("Minus sign ends a string or appears for a non-negative value.");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ((rem_r < radix_r) && (radix_r >= 6'd2)))
    else $error("Divider remainder out of range.");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r <= ND_W'(VALUE_WIDTH))
    else $error("Digit count exceeds the value width.");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r != '0))
    else $error("Divider entered with no bytes to process.");
`endif

endmodule

>>> tb/tb_integer_to_ascii_digits.sv
// Self-checking testbench for integer_to_ascii_digits: directed and random numbers in all radixes,
// every output character checked against a digit string predicted inside the testbench.
// Depends on iad_pkg and the integer_to_ascii_digits RTL.
`timescale 1ns / 100ps

module tb_integer_to_ascii_digits;
  import iad_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } char_word_t;

  class digit_string_board;
    char_word_t expected_chars[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_number(input logic [IN_W-1:0] value, input logic [BASE_W-1:0] base);
      logic [IN_W-1:0]   magnitude;
      logic [IN_W-1:0]   digit;
      logic [BASE_W-1:0] radix;
      logic [CHAR_W-1:0] reversed[$];
      bit                negative;
      if (value == '0 || base < 2) begin
        expected_chars.push_back('{CH_ZERO, 1'b1});
        return;
      end
      radix = (base > MAX_RADIX) ? MAX_RADIX : base;
      magnitude = value;
      negative = 1'b0;
      if (radix == DECIMAL && value[IN_W-1]) begin
        negative = 1'b1;
        magnitude = -value;
      end
      while (magnitude != '0) begin
        digit = magnitude % IN_W'(radix);
        if (digit < IN_W'(DECIMAL)) begin
          reversed.push_back(CH_ZERO + CHAR_W'(digit));
        end else begin
          reversed.push_back(CH_LETTER_A + CHAR_W'(digit - IN_W'(DECIMAL)));
        end
        magnitude = magnitude / IN_W'(radix);
      end
      if (negative) begin
        expected_chars.push_back('{CH_MINUS, 1'b0});
      end
      for (int i = reversed.size() - 1; i >= 0; i--) begin
        expected_chars.push_back('{reversed[i], i == 0});
      end
    endfunction

    function void check_char(input logic [CHAR_W-1:0] character, input logic last);
      char_word_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected word: character %h last %b", character, last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (character !== want.character) begin
        $error("character: expected %h, got %h", want.character, character);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, got %b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [IN_W-1:0]   in_value;
  logic [BASE_W-1:0]        in_base;
  logic                     out_valid;
  logic                     out_stall;
  logic [CHAR_W-1:0]        out_character;
  logic                     out_last;

  digit_string_board board;
  bit                no_idle;
  bit                hold_request;

  integer_to_ascii_digits dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value(in_value),
    .in_base(in_base),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_character(out_character),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_integer_to_ascii_digits: errors");
    $finish;
  end

  task automatic send_number(input logic [IN_W-1:0] value, input logic [BASE_W-1:0] base);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_base  <= base;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_number(value, base);
  endtask

  initial begin : receiver
    int gap;
    out_stall <= 1'b1;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_char(out_character, out_last);
    end
  end

  initial begin : stimulus
    logic [IN_W-1:0]   value;
    logic [BASE_W-1:0] base;
    logic [IN_W-1:0]   directed_values[$];
    logic [BASE_W-1:0] directed_bases[$];
    board = new();
    no_idle = 1'b0;
    hold_request = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_value  <= '0;
    in_base   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed_values = '{64'd0, 64'd0, 64'd12345, 64'd12345, 64'd1,
                        64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                        64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'hFFFF_FFFF_FFFF_FFFF, 64'd35, 64'd36, 64'd10,
                        64'hFFFF_FFFF_FFFF_FFF7, 64'd123456789, 64'd123456789,
                        64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                        64'hDEAD_BEEF_0123_4567, 64'd255, 64'h8000_0000_0000_0000};
    directed_bases  = '{6'd10, 6'd2, 6'd0, 6'd1, 6'd10,
                        6'd10, 6'd10,
                        6'd10, 6'd2,
                        6'd16, 6'd36, 6'd36, 6'd11,
                        6'd10, 6'd37, 6'd63,
                        6'd2, 6'd8,
                        6'd16, 6'd16, 6'd36};
    foreach (directed_values[i]) begin
      send_number(directed_values[i], directed_bases[i]);
    end

    for (int n = 0; n < 450; n++) begin
      if (n % 60 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      if (n == 120) begin
        no_idle = 1'b0;
        hold_request = 1'b1;
      end
      value = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: value = value >> $urandom_range(1, 63);
        1: value = value >> $urandom_range(40, 63);
        2: value = -(value >> $urandom_range(1, 63));
        3: value = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: base = DECIMAL;
        3:       base = 6'd16;
        4:       base = ($urandom_range(0, 3) == 0) ? 6'd2 : 6'd8;
        default: base = BASE_W'($urandom_range(0, 63));
      endcase
      send_number(value, base);
    end
    in_valid <= 1'b0;

    while (board.expected_chars.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.mismatches == 0 && board.expected_chars.size() == 0) begin
      $display("tb_integer_to_ascii_digits: clean");
    end else begin
      $display("tb_integer_to_ascii_digits: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/iad_pkg.sv
hw/rtl/integer_to_ascii_digits.sv
tb/tb_integer_to_ascii_digits.sv
